// ===== rtl/i2crbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crbm_pkg
// shared types, codes and constants of the i2c register burst master
// ----------------------------------------------------------------------------
package i2crbm_pkg;

    localparam int MAX_BURST = 16;
    localparam int FILL_W    = $clog2(MAX_BURST + 1);
    localparam int IDX_W     = $clog2(MAX_BURST);

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_PUSH  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_DEV     = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_PHASE   = 2'd2;
    localparam logic [1:0] REG_SS      = 2'd3;

    // bus phases
    localparam logic [3:0] P_IDLE        = 4'd0;
    localparam logic [3:0] P_START_SETUP = 4'd1;
    localparam logic [3:0] P_START_HOLD  = 4'd2;
    localparam logic [3:0] P_SEND_LOW    = 4'd3;
    localparam logic [3:0] P_SEND_HIGH   = 4'd4;
    localparam logic [3:0] P_SEND_TAIL   = 4'd5;
    localparam logic [3:0] P_ACK_LOW     = 4'd6;
    localparam logic [3:0] P_ACK_HIGH    = 4'd7;
    localparam logic [3:0] P_RECV_LOW    = 4'd8;
    localparam logic [3:0] P_RECV_HIGH   = 4'd9;
    localparam logic [3:0] P_MACK_LOW    = 4'd10;
    localparam logic [3:0] P_MACK_HIGH   = 4'd11;
    localparam logic [3:0] P_STOP_LOW    = 4'd12;
    localparam logic [3:0] P_STOP_SETUP  = 4'd13;
    localparam logic [3:0] P_STOP_HIGH   = 4'd14;

    // burst stages
    localparam logic [1:0] S_ADDR_W = 2'd0;
    localparam logic [1:0] S_REG    = 2'd1;
    localparam logic [1:0] S_ADDR_R = 2'd2;
    localparam logic [1:0] S_DATA   = 2'd3;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] register_address;
        logic [4:0] transfer_length;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       done_res;
        logic       nack_error;
    } t_out;

    // classified word from front to back
    typedef struct packed {
        logic       is_tick;
        logic       is_begin;
        logic       is_read;
        logic       is_push;
        logic [7:0] register_address;
        logic [4:0] length;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_op;

endpackage

// ===== rtl/i2crbm_front.sv =====
// ----------------------------------------------------------------------------
// i2crbm_front
// decodes input words and saturates the burst length into a short queue
// ----------------------------------------------------------------------------
module i2crbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  i2crbm_pkg::t_in   i_data,
    output logic              o_valid,
    input  logic              i_take,
    output i2crbm_pkg::t_op   o_op
);
    i2crbm_pkg::t_op r_q [i2crbm_pkg::QDEPTH];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    i2crbm_pkg::t_op w_op;
    logic            w_in, w_out;

    // classify
    always_comb begin
        w_op = '0;
        unique case (i_data.command)
            i2crbm_pkg::CMD_TICK:  w_op.is_tick = 1'b1;
            i2crbm_pkg::CMD_READ:  begin w_op.is_begin = 1'b1; w_op.is_read = 1'b1; end
            i2crbm_pkg::CMD_WRITE: w_op.is_begin = 1'b1;
            default:               w_op.is_push = 1'b1;
        endcase
        w_op.register_address = i_data.register_address;
        w_op.length = (i_data.transfer_length > 5'(i2crbm_pkg::MAX_BURST))
                    ? 5'(i2crbm_pkg::MAX_BURST) : i_data.transfer_length;
        w_op.write_byte = i_data.write_byte;
        w_op.sda_in     = i_data.sda_in;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_q[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= w_op;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_in)  r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end
endmodule

// ===== rtl/i2crbm_back.sv =====
// ----------------------------------------------------------------------------
// i2crbm_back
// bus sequencer: one queued word per cycle while the result queue has room, results into a two-entry queue
// ----------------------------------------------------------------------------
module i2crbm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_take,
    input  i2crbm_pkg::t_op   i_op,
    input  logic [6:0]        i_dev,
    input  logic [7:0]        i_timeout,
    input  logic [7:0]        i_phase_t,
    input  logic [7:0]        i_ss_t,
    output logic              o_empty,
    input  logic              i_pop,
    output i2crbm_pkg::t_out  o_res
);
    logic [3:0] r_phase, n_phase;
    logic [2:0] r_bit, n_bit;
    logic [4:0] r_byte, n_byte;
    logic [7:0] r_sh, n_sh;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_ackw, n_ackw;
    logic [i2crbm_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [7:0] r_reg, n_reg;
    logic [4:0] r_len, n_len;
    logic       r_rd, n_rd;
    logic [1:0] r_stage, n_stage;
    logic       r_fail, n_fail;
    logic [7:0] r_store [i2crbm_pkg::MAX_BURST];

    i2crbm_pkg::t_out r_oq [2];
    logic             r_owp, r_orp;
    logic [1:0]       r_ocnt;
    i2crbm_pkg::t_out w_res;
    logic             w_go, w_over, w_store_wr, w_last;
    logic [7:0]       w_dur;
    logic [4:0]       w_bnext;
    logic [7:0]       w_sdat;

    assign o_take  = i_valid && (r_ocnt != 2'd2);
    assign w_go    = o_take;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];
    assign w_last  = (6'(r_byte) + 6'd1) >= 6'(r_len);
    assign w_bnext = r_byte + 5'd1;

    // duration of current phase and timer compare
    always_comb begin
        unique case (r_phase)
            i2crbm_pkg::P_START_SETUP, i2crbm_pkg::P_START_HOLD,
            i2crbm_pkg::P_STOP_LOW, i2crbm_pkg::P_STOP_SETUP,
            i2crbm_pkg::P_STOP_HIGH: w_dur = i_ss_t;
            default:                 w_dur = i_phase_t;
        endcase
        if (w_dur == 8'd0) w_dur = 8'd1;
        w_over = (9'(r_tick) + 9'd1) >= 9'(w_dur);
    end

    // store read for the next data byte
    always_comb begin
        w_sdat = 8'd0;
        if (w_bnext < 5'(i2crbm_pkg::MAX_BURST))
            w_sdat = r_store[w_bnext[i2crbm_pkg::IDX_W-1:0]];
    end

    // sequencer
    always_comb begin
        n_phase = r_phase; n_bit = r_bit; n_byte = r_byte; n_sh = r_sh;
        n_tick = r_tick; n_ackw = r_ackw; n_fill = r_fill; n_reg = r_reg;
        n_len = r_len; n_rd = r_rd; n_stage = r_stage; n_fail = r_fail;
        w_store_wr = 1'b0;
        w_res = '0;
        if (i_op.is_begin) begin
            if (r_phase == i2crbm_pkg::P_IDLE) begin
                n_reg = i_op.register_address; n_len = i_op.length;
                n_rd = i_op.is_read; n_stage = i2crbm_pkg::S_ADDR_W;
                n_fail = 1'b0; n_byte = 5'd0;
                n_phase = i2crbm_pkg::P_START_SETUP; n_tick = 8'd0; n_ackw = 8'd0;
            end
        end else if (i_op.is_push) begin
            if (r_phase == i2crbm_pkg::P_IDLE
                && r_fill < i2crbm_pkg::FILL_W'(i2crbm_pkg::MAX_BURST)) begin
                w_store_wr = 1'b1;
                n_fill = r_fill + 1'b1;
            end
        end else begin
            n_tick = w_over ? 8'd0 : r_tick + 8'd1;
            unique case (r_phase)
                i2crbm_pkg::P_START_SETUP:
                    if (w_over) begin n_phase = i2crbm_pkg::P_START_HOLD; n_ackw = 8'd0; end
                i2crbm_pkg::P_START_HOLD:
                    if (w_over) begin
                        n_sh = {i_dev, r_stage == i2crbm_pkg::S_ADDR_R};
                        n_bit = 3'd0; n_phase = i2crbm_pkg::P_SEND_LOW; n_ackw = 8'd0;
                    end
                i2crbm_pkg::P_SEND_LOW:
                    if (w_over) begin n_phase = i2crbm_pkg::P_SEND_HIGH; n_ackw = 8'd0; end
                i2crbm_pkg::P_SEND_HIGH:
                    if (w_over) begin n_phase = i2crbm_pkg::P_SEND_TAIL; n_ackw = 8'd0; end
                i2crbm_pkg::P_SEND_TAIL:
                    if (w_over) begin
                        n_sh = {r_sh[6:0], 1'b0}; n_ackw = 8'd0;
                        if (r_bit == 3'd7) n_phase = i2crbm_pkg::P_ACK_LOW;
                        else begin n_bit = r_bit + 3'd1; n_phase = i2crbm_pkg::P_SEND_LOW; end
                    end
                i2crbm_pkg::P_ACK_LOW: begin
                    n_phase = i2crbm_pkg::P_ACK_HIGH; n_tick = 8'd0; n_ackw = 8'd0;
                end
                i2crbm_pkg::P_ACK_HIGH: begin
                    n_tick = r_tick;
                    if (!i_op.sda_in) begin
                        n_tick = 8'd0; n_ackw = 8'd0;
                        unique case (r_stage)
                            i2crbm_pkg::S_ADDR_W: begin
                                n_stage = i2crbm_pkg::S_REG; n_sh = r_reg;
                                n_bit = 3'd0; n_phase = i2crbm_pkg::P_SEND_LOW;
                            end
                            i2crbm_pkg::S_REG:
                                if (r_rd) begin
                                    n_stage = i2crbm_pkg::S_ADDR_R;
                                    n_phase = i2crbm_pkg::P_START_SETUP;
                                end else if (r_len == 5'd0) begin
                                    n_fail = 1'b0; n_phase = i2crbm_pkg::P_STOP_LOW;
                                end else begin
                                    n_stage = i2crbm_pkg::S_DATA; n_byte = 5'd0;
                                    n_sh = r_store[0]; n_bit = 3'd0;
                                    n_phase = i2crbm_pkg::P_SEND_LOW;
                                end
                            i2crbm_pkg::S_ADDR_R:
                                if (r_len == 5'd0) begin
                                    n_fail = 1'b0; n_phase = i2crbm_pkg::P_STOP_LOW;
                                end else begin
                                    n_byte = 5'd0; n_bit = 3'd0; n_sh = 8'd0;
                                    n_phase = i2crbm_pkg::P_RECV_LOW;
                                end
                            default: begin
                                n_byte = w_bnext;
                                if (w_bnext >= r_len) begin
                                    n_fail = 1'b0; n_phase = i2crbm_pkg::P_STOP_LOW;
                                end else begin
                                    n_sh = w_sdat; n_bit = 3'd0;
                                    n_phase = i2crbm_pkg::P_SEND_LOW;
                                end
                            end
                        endcase
                    end else if (r_ackw >= i_timeout) begin
                        n_fail = 1'b1; n_phase = i2crbm_pkg::P_STOP_LOW;
                        n_tick = 8'd0; n_ackw = 8'd0;
                    end else begin
                        n_ackw = r_ackw + 8'd1;
                    end
                end
                i2crbm_pkg::P_RECV_LOW:
                    if (w_over) begin n_phase = i2crbm_pkg::P_RECV_HIGH; n_ackw = 8'd0; end
                i2crbm_pkg::P_RECV_HIGH: begin
                    if (r_tick == 8'd0) n_sh = {r_sh[6:0], i_op.sda_in};
                    if (w_over) begin
                        n_ackw = 8'd0;
                        if (r_bit == 3'd7) n_phase = i2crbm_pkg::P_MACK_LOW;
                        else begin n_bit = r_bit + 3'd1; n_phase = i2crbm_pkg::P_RECV_LOW; end
                    end
                end
                i2crbm_pkg::P_MACK_LOW:
                    if (w_over) begin n_phase = i2crbm_pkg::P_MACK_HIGH; n_ackw = 8'd0; end
                i2crbm_pkg::P_MACK_HIGH:
                    if (w_over) begin
                        w_res.read_valid = 1'b1; w_res.read_byte = r_sh;
                        w_res.read_last = w_last;
                        n_byte = w_bnext; n_ackw = 8'd0;
                        if (w_bnext >= r_len) begin
                            n_fail = 1'b0; n_phase = i2crbm_pkg::P_STOP_LOW;
                        end else begin
                            n_bit = 3'd0; n_sh = 8'd0; n_phase = i2crbm_pkg::P_RECV_LOW;
                        end
                    end
                i2crbm_pkg::P_STOP_LOW:
                    if (w_over) begin n_phase = i2crbm_pkg::P_STOP_SETUP; n_ackw = 8'd0; end
                i2crbm_pkg::P_STOP_SETUP:
                    if (w_over) begin n_phase = i2crbm_pkg::P_STOP_HIGH; n_ackw = 8'd0; end
                i2crbm_pkg::P_STOP_HIGH:
                    if (w_over) begin
                        w_res.done_res = 1'b1; w_res.nack_error = r_fail;
                        if (!r_rd) n_fill = '0;
                        n_fail = 1'b0; n_phase = i2crbm_pkg::P_IDLE; n_ackw = 8'd0;
                    end
                default: begin
                    n_phase = i2crbm_pkg::P_IDLE; n_tick = r_tick;
                end
            endcase
        end
        // line levels: before a tick, after a command
        begin
            logic [3:0] lp;
            logic       lb, ll;
            lp = i_op.is_tick ? r_phase : n_phase;
            lb = i_op.is_tick ? r_sh[7] : n_sh[7];
            ll = w_last;
            w_res.scl_level = 1'b1; w_res.sda_pull_low = 1'b0;
            unique case (lp)
                i2crbm_pkg::P_START_HOLD: w_res.sda_pull_low = 1'b1;
                i2crbm_pkg::P_SEND_LOW, i2crbm_pkg::P_SEND_TAIL: begin
                    w_res.scl_level = 1'b0; w_res.sda_pull_low = !lb;
                end
                i2crbm_pkg::P_SEND_HIGH: w_res.sda_pull_low = !lb;
                i2crbm_pkg::P_ACK_LOW, i2crbm_pkg::P_RECV_LOW: w_res.scl_level = 1'b0;
                i2crbm_pkg::P_MACK_LOW: begin
                    w_res.scl_level = 1'b0; w_res.sda_pull_low = !ll;
                end
                i2crbm_pkg::P_MACK_HIGH: w_res.sda_pull_low = !ll;
                i2crbm_pkg::P_STOP_LOW: begin
                    w_res.scl_level = 1'b0; w_res.sda_pull_low = 1'b1;
                end
                i2crbm_pkg::P_STOP_SETUP: w_res.sda_pull_low = 1'b1;
                default: ;
            endcase
            w_res.busy_res = (lp != i2crbm_pkg::P_IDLE);
        end
    end

    // write byte store
    always_ff @(posedge i_clk) begin
        if (w_go && w_store_wr) begin
            r_store[r_fill[i2crbm_pkg::IDX_W-1:0]] <= i_op.write_byte;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2crbm_pkg::P_IDLE; r_bit <= '0; r_byte <= '0; r_sh <= '0;
            r_tick <= '0; r_ackw <= '0; r_fill <= '0; r_reg <= '0; r_len <= '0;
            r_rd <= 1'b0; r_stage <= i2crbm_pkg::S_ADDR_W; r_fail <= 1'b0;
        end else if (w_go) begin
            r_phase <= n_phase; r_bit <= n_bit; r_byte <= n_byte; r_sh <= n_sh;
            r_tick <= n_tick; r_ackw <= n_ackw; r_fill <= n_fill; r_reg <= n_reg;
            r_len <= n_len; r_rd <= n_rd; r_stage <= n_stage; r_fail <= n_fail;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_go) r_oq[r_owp] <= w_res;
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp <= 1'b0; r_orp <= 1'b0; r_ocnt <= 2'd0;
        end else begin
            if (w_go) r_owp <= ~r_owp;
            if (i_pop && !o_empty) r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_go) - 2'(i_pop && !o_empty);
        end
    end
endmodule

// ===== rtl/i2c_register_burst_master.sv =====
// ----------------------------------------------------------------------------
// i2c_register_burst_master
// i2c register read/write burst engine stepped by timebase tick words
// ----------------------------------------------------------------------------
// Each input word is a timebase tick or a command and yields exactly one
// result word with the bus levels, status and any received byte. Words flow
// at one per cycle while the result queue has room: a two-entry input queue
// feeds the sequencer, which handles one word per cycle into a two-entry
// result queue and stalls while it is full; its next-state logic is combinational.
module i2c_register_burst_master (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  i2crbm_pkg::t_in   i_data,
    output logic              empty,
    input  logic              pop,
    output i2crbm_pkg::t_out  o_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    logic [6:0] r_dev;
    logic [7:0] r_timeout, r_phase_t, r_ss_t;
    logic       w_valid, w_take;
    i2crbm_pkg::t_op w_op;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= 7'd0; r_timeout <= 8'd250; r_phase_t <= 8'd2; r_ss_t <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2crbm_pkg::REG_DEV:     r_dev     <= i_cfg_data[6:0];
                i2crbm_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data;
                i2crbm_pkg::REG_PHASE:   r_phase_t <= i_cfg_data;
                default:                 r_ss_t    <= i_cfg_data;
            endcase
        end
    end

    i2crbm_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_data,
        .o_valid(w_valid), .i_take(w_take), .o_op(w_op)
    );

    i2crbm_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .o_take(w_take), .i_op(w_op),
        .i_dev(r_dev), .i_timeout(r_timeout), .i_phase_t(r_phase_t),
        .i_ss_t(r_ss_t), .o_empty(empty), .i_pop(pop), .o_res(o_data)
    );

`ifndef SYNTHESIS
    // a done word never carries a read byte
    a_done_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_data.done_res && o_data.read_valid)) else $error("done with data");
    // an error is only reported with done
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_data.nack_error |-> o_data.done_res) else $error("stray error");
    // a read byte is presented only while busy
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_data.read_valid |-> o_data.busy_res) else $error("read when idle");
`endif
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the i2c register burst master: random read and
// write bursts, ticks and pushes against a cycle-free model of the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import i2crbm_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in        i_data = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out       o_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    i2c_register_burst_master u_top (.*);

    always #5 i_clk = ~i_clk;

    // burst stage codes of the model
    localparam logic [1:0] ST_ADDR_W = 2'd0;
    localparam logic [1:0] ST_REG    = 2'd1;
    localparam logic [1:0] ST_ADDR_R = 2'd2;
    localparam logic [1:0] ST_DATA   = 2'd3;

    // model state
    logic [6:0] m_dev;
    logic [7:0] m_tmo, m_pht, m_sst;
    logic [3:0] m_phase;
    logic [2:0] m_bit;
    logic [4:0] m_byte, m_fill, m_len;
    logic [7:0] m_shift, m_tick, m_wait, m_reg;
    logic [7:0] m_store [MAX_BURST];
    logic       m_rd, m_failed;
    logic [1:0] m_stage;

    t_in  word_q [$];
    t_out bus_expect_q [$];
    int   errors = 0;
    int   send_idle = 19, recv_idle = 82;
    bit   stim_done = 0, hold_send = 0;

    function automatic void go(logic [3:0] p);
        m_phase = p; m_tick = 0; m_wait = 0;
    endfunction

    function automatic bit dur_over(logic [7:0] d);
        int dd;
        dd = (d == 0) ? 1 : d;
        if (m_tick + 1 >= dd) begin
            m_tick = 0;
            return 1;
        end
        m_tick++;
        return 0;
    endfunction

    function automatic void send_byte(logic [7:0] b);
        m_shift = b; m_bit = 0; go(P_SEND_LOW);
    endfunction

    function automatic void begin_stop(bit err);
        m_failed = err; go(P_STOP_LOW);
    endfunction

    function automatic bit is_last();
        return (m_byte + 1) >= m_len;
    endfunction

    function automatic void after_ack();
        case (m_stage)
            ST_ADDR_W: begin
                m_stage = ST_REG; send_byte(m_reg);
            end
            ST_REG: begin
                if (m_rd) begin
                    m_stage = ST_ADDR_R; go(P_START_SETUP);
                end else if (m_len == 0) begin_stop(0);
                else begin
                    m_stage = ST_DATA; m_byte = 0; send_byte(m_store[0]);
                end
            end
            ST_ADDR_R: begin
                if (m_len == 0) begin_stop(0);
                else begin
                    m_byte = 0; m_bit = 0; m_shift = 0; go(P_RECV_LOW);
                end
            end
            default: begin
                m_byte++;
                if (m_byte >= m_len) begin_stop(0);
                else send_byte(m_store[m_byte[3:0]]);
            end
        endcase
    endfunction

    function automatic void put_levels(ref t_out r);
        logic b;
        b = m_shift[7];
        r.scl_level = 1; r.sda_pull_low = 0;
        case (m_phase)
            P_START_HOLD: r.sda_pull_low = 1;
            P_SEND_LOW, P_SEND_TAIL: begin
                r.scl_level = 0; r.sda_pull_low = !b;
            end
            P_SEND_HIGH: r.sda_pull_low = !b;
            P_ACK_LOW, P_RECV_LOW: r.scl_level = 0;
            P_MACK_LOW: begin
                r.scl_level = 0; r.sda_pull_low = !is_last();
            end
            P_MACK_HIGH: r.sda_pull_low = !is_last();
            P_STOP_LOW: begin
                r.scl_level = 0; r.sda_pull_low = 1;
            end
            P_STOP_SETUP: r.sda_pull_low = 1;
            default: ;
        endcase
        r.busy_res = m_phase != P_IDLE;
    endfunction

    function automatic t_out bus_step(t_in w);
        t_out r;
        r = '0;
        if (w.command == CMD_READ || w.command == CMD_WRITE) begin
            if (m_phase == P_IDLE) begin
                m_reg = w.register_address;
                m_len = (w.transfer_length > MAX_BURST) ? MAX_BURST : w.transfer_length;
                m_rd = w.command == CMD_READ;
                m_stage = ST_ADDR_W; m_failed = 0; m_byte = 0;
                go(P_START_SETUP);
            end
            put_levels(r);
            return r;
        end
        if (w.command == CMD_PUSH) begin
            if (m_phase == P_IDLE && m_fill < MAX_BURST) begin
                m_store[m_fill[3:0]] = w.write_byte; m_fill++;
            end
            put_levels(r);
            return r;
        end
        put_levels(r);
        case (m_phase)
            P_START_SETUP: if (dur_over(m_sst)) go(P_START_HOLD);
            P_START_HOLD: if (dur_over(m_sst))
                send_byte({m_dev, m_stage == ST_ADDR_R});
            P_SEND_LOW: if (dur_over(m_pht)) go(P_SEND_HIGH);
            P_SEND_HIGH: if (dur_over(m_pht)) go(P_SEND_TAIL);
            P_SEND_TAIL: if (dur_over(m_pht)) begin
                m_shift = m_shift << 1;
                if (m_bit >= 7) go(P_ACK_LOW);
                else begin
                    m_bit++; go(P_SEND_LOW);
                end
            end
            P_ACK_LOW: go(P_ACK_HIGH);
            P_ACK_HIGH: begin
                if (!w.sda_in) after_ack();
                else if (m_wait >= m_tmo) begin_stop(1);
                else m_wait++;
            end
            P_RECV_LOW: if (dur_over(m_pht)) go(P_RECV_HIGH);
            P_RECV_HIGH: begin
                if (m_tick == 0) m_shift = {m_shift[6:0], w.sda_in};
                if (dur_over(m_pht)) begin
                    if (m_bit >= 7) go(P_MACK_LOW);
                    else begin
                        m_bit++; go(P_RECV_LOW);
                    end
                end
            end
            P_MACK_LOW: if (dur_over(m_pht)) go(P_MACK_HIGH);
            P_MACK_HIGH: if (dur_over(m_pht)) begin
                r.read_valid = 1; r.read_byte = m_shift; r.read_last = is_last();
                m_byte++;
                if (m_byte >= m_len) begin_stop(0);
                else begin
                    m_bit = 0; m_shift = 0; go(P_RECV_LOW);
                end
            end
            P_STOP_LOW: if (dur_over(m_sst)) go(P_STOP_SETUP);
            P_STOP_SETUP: if (dur_over(m_sst)) go(P_STOP_HIGH);
            P_STOP_HIGH: if (dur_over(m_sst)) begin
                r.done_res = 1; r.nack_error = m_failed;
                if (!m_rd) m_fill = 0;
                m_failed = 0;
                go(P_IDLE);
            end
            default: m_phase = P_IDLE;
        endcase
        return r;
    endfunction

    // word generators
    function automatic t_in mk(logic [1:0] c, logic [7:0] ra, logic [4:0] ln,
                               logic [7:0] wb, logic s);
        t_in w;
        w.command = c; w.register_address = ra; w.transfer_length = ln;
        w.write_byte = wb; w.sda_in = s;
        return w;
    endfunction

    function automatic t_in rnd_word(logic [1:0] c, logic s);
        return mk(c, $urandom, $urandom, $urandom, s);
    endfunction

    // sda mostly acks, with occasional long nack runs
    int nack_run = 0;
    function automatic logic sda_pick();
        if (nack_run > 0) begin
            nack_run--;
            return 1;
        end
        if ($urandom_range(0, 60) == 0) nack_run = $urandom_range(1, 300);
        return $urandom_range(0, 3) == 0;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) void'(word_q.pop_front());
            if (word_q.size() != 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle) begin
                push <= 1'b1;
                i_data <= word_q[0];
            end else begin
                push <= 1'b0;
            end
            pop <= $urandom_range(0, 99) >= recv_idle;
        end
    end

    // monitor
    int quiet = 0;
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n) begin
            quiet++;
            if (push && !full) begin
                bus_expect_q.push_back(bus_step(i_data));
                quiet = 0;
            end
            if (pop && !empty) begin
                quiet = 0;
                if (bus_expect_q.size() == 0) begin
                    $error("unexpected result word");
                    errors++;
                end else begin
                    e = bus_expect_q.pop_front();
                    if (o_data.scl_level !== e.scl_level) begin
                        $error("scl_level exp %0d got %0d", e.scl_level, o_data.scl_level);
                        errors++;
                    end
                    if (o_data.sda_pull_low !== e.sda_pull_low) begin
                        $error("sda_pull_low exp %0d got %0d", e.sda_pull_low,
                               o_data.sda_pull_low);
                        errors++;
                    end
                    if (o_data.busy_res !== e.busy_res) begin
                        $error("busy_res exp %0d got %0d", e.busy_res, o_data.busy_res);
                        errors++;
                    end
                    if (o_data.read_valid !== e.read_valid) begin
                        $error("read_valid exp %0d got %0d", e.read_valid, o_data.read_valid);
                        errors++;
                    end
                    if (o_data.read_byte !== e.read_byte) begin
                        $error("read_byte exp %0h got %0h", e.read_byte, o_data.read_byte);
                        errors++;
                    end
                    if (o_data.read_last !== e.read_last) begin
                        $error("read_last exp %0d got %0d", e.read_last, o_data.read_last);
                        errors++;
                    end
                    if (o_data.done_res !== e.done_res) begin
                        $error("done_res exp %0d got %0d", e.done_res, o_data.done_res);
                        errors++;
                    end
                    if (o_data.nack_error !== e.nack_error) begin
                        $error("nack_error exp %0d got %0d", e.nack_error, o_data.nack_error);
                        errors++;
                    end
                end
            end
            if (quiet > 20000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DEV:     m_dev = val[6:0];
            REG_TIMEOUT: m_tmo = val;
            REG_PHASE:   m_pht = val;
            default:     m_sst = val;
        endcase
    endtask

    task automatic drain();
        wait (word_q.size() == 0 && !push);
        wait (bus_expect_q.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    // one burst of random length; pushes fill the store first for writes
    task automatic add_burst(bit rd, int ln);
        int n;
        if (!rd) begin
            if (m_fill_gen < ln) begin
                for (int k = m_fill_gen; k < ln; k++)
                    word_q.push_back(rnd_word(CMD_PUSH, $urandom));
                m_fill_gen = ln;
            end
        end
        word_q.push_back(mk(rd ? CMD_READ : CMD_WRITE, $urandom, ln, $urandom, $urandom));
        n = 0;
        // burst_ticks tick words, with a stray read, write or push now and then
        while (n < burst_ticks) begin
            word_q.push_back(rnd_word(CMD_TICK, sda_pick()));
            if ($urandom_range(0, 40) == 0)
                word_q.push_back(rnd_word($urandom_range(1, 3), $urandom));
            n++;
        end
    endtask

    // generation-side copy of the store fill: writes are sized to the pushes
    int m_fill_gen = 0;
    int burst_ticks;

    initial begin
        int total;
        logic [7:0] pt, st, to;
        m_dev = 0; m_tmo = 250; m_pht = 2; m_sst = 5;
        m_phase = P_IDLE; m_bit = 0; m_byte = 0; m_fill = 0; m_len = 0;
        m_shift = 0; m_tick = 0; m_wait = 0; m_reg = 0; m_rd = 0;
        m_failed = 0; m_stage = ST_ADDR_W;
        foreach (m_store[k]) m_store[k] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero length, extremes, all commands
        cfg_write(REG_DEV, 8'h7f);
        word_q.push_back(mk(CMD_PUSH, 0, 0, 8'hff, 0));
        word_q.push_back(mk(CMD_PUSH, 0, 0, 8'h00, 0));
        word_q.push_back(mk(CMD_WRITE, 8'hff, 5'd2, 0, 0));
        word_q.push_back(mk(CMD_READ, 0, 5'd1, 0, 0));
        for (int k = 0; k < 120; k++) word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0));
        m_fill_gen = 0;
        word_q.push_back(mk(CMD_READ, 8'h00, 5'd31, 0, 0));
        for (int k = 0; k < 700; k++)
            word_q.push_back(mk(CMD_TICK, 8'hff, 5'h1f, 8'hff, k[0]));
        word_q.push_back(mk(CMD_READ, 8'h5a, 5'd0, 0, 0));
        for (int k = 0; k < 120; k++) word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0));
        drain();

        total = 0;
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle = 82; recv_idle = 19;
            end else if (ph == 6) begin
                send_idle = 0; recv_idle = 0;
            end
            case (ph % 3)
                0: begin pt = 1; st = 1; to = $urandom_range(0, 3); end
                1: begin pt = 0; st = 0; to = 0; end
                default: begin
                    pt = $urandom_range(1, 3); st = $urandom_range(1, 6);
                    to = (ph == 8) ? 8'hff : $urandom_range(1, 20);
                end
            endcase
            cfg_write(REG_DEV, $urandom);
            cfg_write(REG_TIMEOUT, to);
            cfg_write(REG_PHASE, pt);
            cfg_write(REG_SS, st);
            for (int b = 0; b < 4; b++) begin
                int ln;
                bit rd;
                ln = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 3);
                rd = $urandom_range(0, 1);
                // tick budget for start, 3 bytes of addressing, data and stop, capped at 400
                burst_ticks = 4 * ((st == 0 ? 1 : st) * 2 + 1) +
                              (ln + 4) * 9 * (3 * (pt == 0 ? 1 : pt) + 2) +
                              2 * (to + 2) + 10;
                if (burst_ticks > 400) burst_ticks = 400;
                add_burst(rd, ln);
                total += burst_ticks;
                if (ph == 7 && b == 1) begin
                    hold_send = 1;
                    wait (word_q.size() <= 0 || bus_expect_q.size() == 0);
                    wait (bus_expect_q.size() == 0);
                    hold_send = 0;
                end
            end
            drain();
            m_fill_gen = m_fill;
        end
        stim_done = 1;
        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
